// File: sv/ansi_csi_sequence_parser_macros.svh
// Assertion helpers used by the parser's output FIFO.
`ifndef ANSI_CSI_SEQUENCE_PARSER_MACROS_SVH
`define ANSI_CSI_SEQUENCE_PARSER_MACROS_SVH

// Same-cycle implication under asynchronous active-low reset.
`define ACSP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("acsp assertion failed");

// Next-cycle implication under asynchronous active-low reset.
`define ACSP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("acsp assertion failed");

`endif

// File: sv/acsp_pkg.sv
`default_nettype none

package acsp_pkg;

	localparam int PARAM_WIDTH_DEF = 16;
	localparam int OQ_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_BKSP  = 2'd1,
		KIND_PARAM = 2'd2,
		KIND_CMD   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] value;
		logic [7:0]  param_index;
		logic [7:0]  param_count;
		logic        last;
	} result_t;

	// Up to two results written into the output queue in one cycle.
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

`default_nettype wire

// File: sv/acsp_in_if.sv
`default_nettype none

interface acsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// File: sv/acsp_out_if.sv
`default_nettype none

interface acsp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] value;
	logic [7:0]  param_index;
	logic [7:0]  param_count;
	logic        last;

	modport source (output valid, output kind, output value, output param_index,
		output param_count, output last, input ready);
	modport sink (input valid, input kind, input value, input param_index,
		input param_count, input last, output ready);
endinterface

`default_nettype wire

// File: sv/acsp_out_fifo.sv
`default_nettype none
`include "ansi_csi_sequence_parser_macros.svh"

module acsp_out_fifo import acsp_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  push_t        push,
	output logic         room,
	acsp_out_if.source   dout
);

	localparam int PTR_W = $clog2(OQ_DEPTH);
	localparam int CNT_W = $clog2(OQ_DEPTH + 1);
	localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(OQ_DEPTH - 2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(OQ_DEPTH);

	result_t          mem_q [OQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	result_t          head;

	assign room = (count_q <= ROOM_MAX);
	assign pop  = dout.valid && dout.ready;
	assign head = mem_q[rd_ptr_q];

	assign dout.valid       = (count_q != '0);
	assign dout.kind        = head.kind;
	assign dout.value       = head.value;
	assign dout.param_index = head.param_index;
	assign dout.param_count = head.param_count;
	assign dout.last        = head.last;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	`ACSP_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_MAX)
	`ACSP_ASSERT_IMP(a_push_room, clk, arst_n, push.n != 2'd0, count_q <= ROOM_MAX)
	`ACSP_ASSERT_IMP(a_pair_last, clk, arst_n, push.n == 2'd2, push.r1.last && !push.r0.last)
	`ACSP_ASSERT_NXT(a_fill_shows, clk, arst_n, count_q == '0 && push.n != 2'd0, dout.valid)

endmodule

`default_nettype wire

// File: sv/ansi_csi_sequence_parser.sv
// ANSI CSI parser: one terminal byte is taken per cycle while the queue has
// room and decoded in the same cycle into zero, one or two result words
// (data byte, backspace, sequence parameter, command final byte) that enter
// a four-word output queue, which registers each word before offering it and
// delivers one word per cycle while the sink is ready. A byte is taken whenever
// the queue has at least two free words, so while the sink is ready a stream
// that yields at most one word per byte runs at one byte per clock. Two bytes
// yield two words: the final byte after parameters (parameter and command),
// and a byte other than '[', CR or ESC after a lone ESC (the ESC and the byte).
`default_nettype none

module ansi_csi_sequence_parser import acsp_pkg::*; #(
	parameter int PARAM_WIDTH = PARAM_WIDTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	acsp_in_if.sink    din,
	acsp_out_if.source dout
);

	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_BS   = 8'h08;
	localparam logic [7:0] CH_DEL  = 8'h7f;
	localparam logic [7:0] CH_ESC  = 8'h1b;
	localparam logic [7:0] CH_LBR  = 8'h5b;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CNT_SAT = 8'hff;

	typedef enum logic [1:0] {
		PH_GROUND = 2'd0,
		PH_ESC    = 2'd1,
		PH_CSI    = 2'd2,
		PH_PARAM  = 2'd3
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [PARAM_WIDTH-1:0] accum_q, accum_d;
	logic [7:0]             fc_q, fc_d;
	logic [7:0]             fc_inc;

	logic [7:0]             b;
	logic                   accept;
	logic                   room;
	logic                   is_digit;
	logic [3:0]             digit;
	logic [PARAM_WIDTH+3:0] prod;
	logic [PARAM_WIDTH-1:0] acc_next;
	logic [15:0]            acc16;

	logic                   g_n;
	logic                   g_esc;
	result_t                g_res;

	logic [1:0]             n;
	result_t                r0, r1;
	push_t                  push;

	assign b        = din.in_byte;
	assign din.ready = room;
	assign accept   = din.valid && room;
	assign is_digit = (b >= CH_0) && (b <= CH_9);
	assign digit    = b[3:0];
	assign fc_inc   = (fc_q != CNT_SAT) ? fc_q + 8'd1 : fc_q;

	// accum * 10 + digit, saturated to the parameter width
	assign prod = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0}
		+ {{PARAM_WIDTH{1'b0}}, digit};
	assign acc_next = (prod[PARAM_WIDTH+3:PARAM_WIDTH] != 4'd0) ? {PARAM_WIDTH{1'b1}}
		: prod[PARAM_WIDTH-1:0];

	generate
		if (PARAM_WIDTH >= 16) begin : g_wide
			assign acc16 = accum_q[15:0];
		end else begin : g_narrow
			assign acc16 = {{(16 - PARAM_WIDTH){1'b0}}, accum_q};
		end
	endgenerate

	// plain ground handling of the current byte
	always_comb begin
		g_n   = 1'b0;
		g_esc = 1'b0;
		g_res = '{kind: KIND_DATA, value: {8'h00, b}, param_index: 8'd0,
			param_count: 8'd0, last: 1'b0};
		if (b == CH_CR) begin
			g_n = 1'b0;
		end else if (b == CH_BS || b == CH_DEL) begin
			g_n = 1'b1;
			g_res.kind  = KIND_BKSP;
			g_res.value = 16'd0;
		end else if (b == CH_ESC) begin
			g_esc = 1'b1;
		end else begin
			g_n = 1'b1;
		end
	end

	always_comb begin
		phase_d = phase_q;
		accum_d = accum_q;
		fc_d    = fc_q;
		n       = 2'd0;
		r0      = g_res;
		r1      = g_res;
		unique case (phase_q)
			PH_GROUND: begin
				n = {1'b0, g_n};
				if (g_esc) begin
					phase_d = PH_ESC;
				end
			end
			PH_ESC: begin
				if (b == CH_LBR) begin
					phase_d = PH_CSI;
					accum_d = '0;
					fc_d    = 8'd0;
				end else begin
					// lone ESC goes out as data, then the byte as in ground
					r0 = '{kind: KIND_DATA, value: {8'h00, CH_ESC}, param_index: 8'd0,
						param_count: 8'd0, last: 1'b0};
					r1 = g_res;
					n  = g_n ? 2'd2 : 2'd1;
					phase_d = g_esc ? PH_ESC : PH_GROUND;
				end
			end
			PH_CSI: begin
				if (is_digit) begin
					accum_d = PARAM_WIDTH'(digit);
					fc_d    = 8'd0;
					phase_d = PH_PARAM;
				end else begin
					r0 = '{kind: KIND_CMD, value: {8'h00, b}, param_index: 8'd0,
						param_count: 8'd0, last: 1'b0};
					n  = 2'd1;
					phase_d = PH_GROUND;
				end
			end
			PH_PARAM: begin
				r0 = '{kind: KIND_PARAM, value: acc16, param_index: fc_q,
					param_count: 8'd0, last: 1'b0};
				if (is_digit) begin
					accum_d = acc_next;
				end else if (b == CH_SEMI) begin
					n       = 2'd1;
					accum_d = '0;
					fc_d    = fc_inc;
				end else begin
					r1 = '{kind: KIND_CMD, value: {8'h00, b}, param_index: 8'd0,
						param_count: fc_inc, last: 1'b0};
					n       = 2'd2;
					accum_d = '0;
					fc_d    = 8'd0;
					phase_d = PH_GROUND;
				end
			end
			default: begin
				phase_d = PH_GROUND;
			end
		endcase
		if (n == 2'd1) begin
			r0.last = 1'b1;
		end
		if (n == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_GROUND;
			accum_q <= '0;
			fc_q    <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			accum_q <= accum_d;
			fc_q    <= fc_d;
		end
	end

	assign push.n  = accept ? n : 2'd0;
	assign push.r0 = r0;
	assign push.r1 = r1;

	acsp_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.dout   (dout)
	);

endmodule

`default_nettype wire

// File: tb/ansi_csi_sequence_parser_tb.sv
`timescale 1ns / 100ps

module ansi_csi_sequence_parser_tb import acsp_pkg::*;;

	localparam int PW          = PARAM_WIDTH_DEF;
	localparam int IDLE_LIMIT  = 5000;
	localparam int DRAIN       = 20;
	localparam int RAND_ITEMS  = 1450;

	localparam logic [7:0] B_BS   = 8'h08;
	localparam logic [7:0] B_CR   = 8'h0d;
	localparam logic [7:0] B_ESC  = 8'h1b;
	localparam logic [7:0] B_ZERO = 8'h30;
	localparam logic [7:0] B_NINE = 8'h39;
	localparam logic [7:0] B_SEMI = 8'h3b;
	localparam logic [7:0] B_LBR  = 8'h5b;
	localparam logic [7:0] B_DEL  = 8'h7f;

	localparam longint unsigned PARAM_MAX = (64'd1 << PW) - 64'd1;

	typedef enum logic [1:0] {
		PH_GROUND = 2'd0,
		PH_ESC    = 2'd1,
		PH_CSI    = 2'd2,
		PH_PARAM  = 2'd3
	} parse_phase_t;

	logic clk;
	logic arst_n;

	acsp_in_if  din_if ();
	acsp_out_if dout_if ();

	ansi_csi_sequence_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	// Stimulus and expectations
	logic [7:0]      byte_q[$];
	bit              hold_q[$];
	result_t         decoded_q[$];
	int              err_count = 0;

	// Parser state mirror
	parse_phase_t    st_phase;
	longint unsigned st_accum;
	logic [7:0]      st_fields;
	result_t         res_buf[2];
	int              res_n;

	int              send_gap;
	int              send_calm;
	int              recv_gap;
	int              recv_calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 59) == 0) begin
			calm = $urandom_range(40, 160);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit is_digit(logic [7:0] b);
		return b >= B_ZERO && b <= B_NINE;
	endfunction

	task automatic note_error(string msg);
		err_count++;
		if (err_count <= 10)
			$display("%s", msg);
	endtask

	task automatic add_res(kind_t k, logic [15:0] v, logic [7:0] idx, logic [7:0] cnt);
		res_buf[res_n].kind        = k;
		res_buf[res_n].value       = v;
		res_buf[res_n].param_index = idx;
		res_buf[res_n].param_count = cnt;
		res_buf[res_n].last        = 1'b0;
		res_n++;
	endtask

	task automatic ground_byte(logic [7:0] b);
		if (b == B_CR) begin
			// drop
		end else if (b == B_BS || b == B_DEL) begin
			add_res(KIND_BKSP, 16'd0, 8'd0, 8'd0);
		end else if (b == B_ESC) begin
			st_phase = PH_ESC;
		end else begin
			add_res(KIND_DATA, {8'h00, b}, 8'd0, 8'd0);
		end
	endtask

	task automatic decode_byte(logic [7:0] b);
		longint unsigned v;
		logic [7:0]      cnt;
		res_n = 0;
		case (st_phase)
			PH_GROUND: begin
				ground_byte(b);
			end
			PH_ESC: begin
				if (b == B_LBR) begin
					st_phase  = PH_CSI;
					st_accum  = 0;
					st_fields = 8'd0;
				end else begin
					add_res(KIND_DATA, {8'h00, B_ESC}, 8'd0, 8'd0);
					st_phase = PH_GROUND;
					ground_byte(b);
				end
			end
			PH_CSI: begin
				if (is_digit(b)) begin
					st_accum  = longint'(b - B_ZERO);
					st_fields = 8'd0;
					st_phase  = PH_PARAM;
				end else begin
					add_res(KIND_CMD, {8'h00, b}, 8'd0, 8'd0);
					st_phase = PH_GROUND;
				end
			end
			default: begin
				if (is_digit(b)) begin
					v = st_accum * 10 + longint'(b - B_ZERO);
					if (v > PARAM_MAX)
						v = PARAM_MAX;
					st_accum = v;
				end else if (b == B_SEMI) begin
					add_res(KIND_PARAM, 16'(st_accum), st_fields, 8'd0);
					if (st_fields != 8'hff)
						st_fields++;
					st_accum = 0;
				end else begin
					cnt = (st_fields != 8'hff) ? st_fields + 8'd1 : 8'hff;
					add_res(KIND_PARAM, 16'(st_accum), st_fields, 8'd0);
					add_res(KIND_CMD, {8'h00, b}, 8'd0, cnt);
					st_accum  = 0;
					st_fields = 8'd0;
					st_phase  = PH_GROUND;
				end
			end
		endcase
		for (int i = 0; i < res_n; i++) begin
			res_buf[i].last = (i == res_n - 1);
			decoded_q = {decoded_q, res_buf[i]};
		end
	endtask

	task automatic push_byte(logic [7:0] b, bit hold = 1'b0);
		byte_q = {byte_q, b};
		hold_q = {hold_q, hold};
	endtask

	task automatic push_str(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_digits(int n);
		for (int i = 0; i < n; i++)
			push_byte(B_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic gen_csi(bit hold);
		int         np;
		logic [7:0] fin;
		push_byte(B_ESC, hold);
		push_byte(B_LBR);
		np = $urandom_range(0, 4);
		for (int i = 0; i < np; i++) begin
			if (i > 0)
				push_byte(B_SEMI);
			if (i == 0)
				push_digits(($urandom_range(0, 9) == 0) ? 7 : $urandom_range(1, 5));
			else
				push_digits($urandom_range(0, 5));
		end
		if (np > 0 && $urandom_range(0, 7) == 0)
			push_byte(B_SEMI);
		if ($urandom_range(0, 4) != 0) begin
			fin = 8'($urandom_range(8'h40, 8'h7e));
		end else begin
			do
				fin = 8'($urandom_range(0, 255));
			while (is_digit(fin) || (np > 0 && fin == B_SEMI));
		end
		push_byte(fin);
	endtask

	task automatic build_stimulus;
		int         r;
		int         n;
		bit         hold;
		bit         long_done;
		logic [7:0] b;
		long_done = 1'b0;
		// ground bytes at the extremes and the special controls
		push_str("A");
		push_byte(8'h00);
		push_byte(8'hff);
		push_byte(B_CR);
		push_byte(B_BS);
		push_byte(B_DEL);
		// sequence without parameters, and ';' right after the opener
		push_byte(B_ESC);
		push_str("[A");
		push_byte(B_ESC);
		push_str("[;");
		// two lone escapes in a row
		push_byte(B_ESC);
		push_byte(B_ESC);
		push_str("x");
		// parameter, empty field, saturated parameter, ESC as the final byte
		push_byte(B_ESC);
		push_str("[7;;70000");
		push_byte(B_ESC);

		while (byte_q.size() < RAND_ITEMS) begin
			hold = (byte_q.size() < 30) || ($urandom_range(0, 150) == 0);
			if (!long_done && byte_q.size() > 700) begin
				// more fields than the counters can hold
				long_done = 1'b1;
				push_byte(B_ESC, hold);
				push_str("[1");
				for (int i = 0; i < 258; i++)
					push_byte(B_SEMI);
				push_str("m");
				continue;
			end
			r = $urandom_range(0, 99);
			if (r < 50) begin
				gen_csi(hold);
			end else if (r < 75) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					push_byte(8'($urandom_range(0, 255)), hold && i == 0);
			end else if (r < 85) begin
				push_byte(B_ESC, hold);
				do
					b = 8'($urandom_range(0, 255));
				while (b == B_LBR);
				push_byte(b);
			end else if (r < 95) begin
				push_byte(B_ESC, hold);
				push_byte(B_LBR);
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++)
					push_byte(8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 2))
					0: push_byte(B_CR, hold);
					1: push_byte(B_BS, hold);
					default: push_byte(B_DEL, hold);
				endcase
			end
		end
	endtask

	// Driver: one byte per word, gaps between words, hold-off on marked items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din_if.valid   <= 1'b0;
			din_if.in_byte <= 8'h00;
			send_gap  = 0;
			send_calm = 0;
		end else if (!din_if.valid || din_if.ready) begin
			if (din_if.valid) begin
				decode_byte(din_if.in_byte);
				void'(byte_q.pop_front());
				void'(hold_q.pop_front());
				send_gap = pick_gap(send_calm);
			end
			if (send_gap > 0) begin
				send_gap--;
				din_if.valid <= 1'b0;
			end else if (byte_q.size() > 0 && !(hold_q[0] && decoded_q.size() != 0)) begin
				din_if.valid   <= 1'b1;
				din_if.in_byte <= byte_q[0];
			end else begin
				din_if.valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each accepted word with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
			recv_gap  = 0;
			recv_calm = 0;
		end else begin
			if (dout_if.valid && dout_if.ready) begin
				if (decoded_q.size() == 0) begin
					note_error($sformatf(
						"unexpected word: kind=%0d value=%0d idx=%0d cnt=%0d last=%0d",
						dout_if.kind, dout_if.value, dout_if.param_index,
						dout_if.param_count, dout_if.last));
				end else if (dout_if.kind !== decoded_q[0].kind
						|| dout_if.value !== decoded_q[0].value
						|| dout_if.param_index !== decoded_q[0].param_index
						|| dout_if.param_count !== decoded_q[0].param_count
						|| dout_if.last !== decoded_q[0].last) begin
					note_error($sformatf({"mismatch: expected kind=%0d value=%0d idx=%0d ",
						"cnt=%0d last=%0d, got kind=%0d value=%0d idx=%0d cnt=%0d last=%0d"},
						decoded_q[0].kind, decoded_q[0].value, decoded_q[0].param_index,
						decoded_q[0].param_count, decoded_q[0].last,
						dout_if.kind, dout_if.value, dout_if.param_index,
						dout_if.param_count, dout_if.last));
				end
				if (decoded_q.size() != 0)
					void'(decoded_q.pop_front());
			end
			if (recv_gap > 0) begin
				recv_gap--;
				dout_if.ready <= 1'b0;
			end else begin
				dout_if.ready <= 1'b1;
				recv_gap = pick_gap(recv_calm);
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
				idle = 0;
			else
				idle++;
		end
		$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		st_phase       = PH_GROUND;
		st_accum       = 0;
		st_fields      = 8'd0;
		build_stimulus();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_q.size() != 0 || decoded_q.size() != 0)
			@(posedge clk);
		// let any stray word surface
		repeat (DRAIN) @(posedge clk);
		if (decoded_q.size() != 0)
			note_error($sformatf("%0d expected words never arrived", decoded_q.size()));

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
